// File: hdl/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the WAV RIFF stream parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // Sticky error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
  localparam logic [2:0] ERR_NOT_WAVE   = 3'd2;
  localparam logic [2:0] ERR_FMT_SMALL  = 3'd3;
  localparam logic [2:0] ERR_NOT_PCM    = 3'd4;
  localparam logic [2:0] ERR_DATA_EARLY = 3'd5;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd6;

  // Four-character codes, little-endian packed
  localparam logic [31:0] FOURCC_RIFF = 32'h4646_4952;
  localparam logic [31:0] FOURCC_WAVE = 32'h4556_4157;
  localparam logic [31:0] FOURCC_FMT  = 32'h2074_6D66;
  localparam logic [31:0] FOURCC_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  // Stream word widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 160;

  // One result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic        format_valid;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } wrp_res_t;

endpackage

// File: hdl/wav_riff_stream_parser.sv
// ----------------------------------------------------------------------------
// wav_riff_stream_parser
// WAV (RIFF/PCM) header parser over a byte stream, one result word per byte.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries the file one byte per word; tlast marks the
//   final byte of the file. Every accepted byte yields exactly one master
//   word: tuser gives its kind (header, payload, error, ignored), tlast
//   flags the final payload byte of the data chunk, and tdata carries the
//   error code, payload byte, captured fmt fields and the data chunk size.
//   A byte accepted into the input register passes wrp_core and lands in
//   the result register once that register can take a word, where its
//   word turns valid. Throughput is one byte per cycle while the master
//   side does not stall, with wrp_core updating its state once per byte.
//   When the master side stalls, the result register holds its word and the
//   input register still takes one more byte; tready drops once both are
//   full. Reset clears all parser state, the format fields and any sticky
//   error, and empties both registers.
// ----------------------------------------------------------------------------
module wav_riff_stream_parser
  import wrp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic                   s_axis_tlast,  // end_of_stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] error_code, [10:3] payload_byte, [11] format_valid,
  // [27:12] channels, [59:28] sample_rate, [91:60] byte_rate,
  // [107:92] block_align, [123:108] bits_per_sample, [155:124] data_size,
  // [159:156] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,  // last_payload
  output logic [1:0]             m_axis_tuser   // [1:0] kind
);

  logic       advance;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       step;
  wrp_res_t   core_res;
  wrp_res_t   out_res;

  assign step = in_valid && advance;

  wrp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .s_eos_i   (s_axis_tlast),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .eos_o     (in_eos)
  );

  wrp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte),
    .eos_i  (in_eos),
    .res_o  (core_res)
  );

  wrp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .res_i     (core_res),
    .advance_o (advance),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (out_res)
  );

  // Pack the result word
  assign m_axis_tdata = {4'd0,
                         out_res.data_size,
                         out_res.bits_per_sample,
                         out_res.block_align,
                         out_res.byte_rate,
                         out_res.sample_rate,
                         out_res.channels,
                         out_res.format_valid,
                         out_res.payload_byte,
                         out_res.error_code};
  assign m_axis_tlast = out_res.last_payload;
  assign m_axis_tuser = out_res.kind;

endmodule

// File: hdl/wrp_in_stage.sv
// ----------------------------------------------------------------------------
// wrp_in_stage
// Input register for the byte stream; frees itself when the core steps.
// ----------------------------------------------------------------------------
module wrp_in_stage
  import wrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  input  logic       s_eos_i,
  input  logic       advance_i,   // downstream takes the held word this cycle
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       eos_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       eos_q;
  logic       load;

  assign s_ready_o = !valid_q || advance_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_byte_i;
      eos_q  <= s_eos_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign eos_o   = eos_q;

endmodule

// File: hdl/wrp_core.sv
// ----------------------------------------------------------------------------
// wrp_core
// Parser state and the per-byte update; produces one result word per step.
// ----------------------------------------------------------------------------
module wrp_core
  import wrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output wrp_res_t   res_o
);

  // Parser phases
  localparam logic [2:0] PH_RIFF    = 3'd0;
  localparam logic [2:0] PH_RSIZE   = 3'd1;
  localparam logic [2:0] PH_WAVE    = 3'd2;
  localparam logic [2:0] PH_HDR     = 3'd3;
  localparam logic [2:0] PH_FMT     = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  logic [2:0]   phase_q, phase_d;
  logic [3:0]   idx_q, idx_d;
  logic [31:0]  shift_q, shift_d;
  logic [31:0]  tag_q, tag_d;
  logic [32:0]  left_q, left_d;
  logic         fmt_seen_q, fmt_seen_d;
  logic [2:0]   err_q, err_d;
  logic [127:0] fmt_q, fmt_d;
  logic [31:0]  dlen_q, dlen_d;

  logic [31:0]  shifted;
  logic [3:0]   idx_inc;
  logic [32:0]  left_dec;
  logic [1:0]   kind;
  logic [7:0]   payload;
  logic         last;

  assign shifted  = {byte_i, shift_q[31:8]};
  assign idx_inc  = idx_q + 4'd1;
  assign left_dec = left_q - 33'd1;

  // Per-byte state update
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    shift_d    = shift_q;
    tag_d      = tag_q;
    left_d     = left_q;
    fmt_seen_d = fmt_seen_q;
    err_d      = err_q;
    fmt_d      = fmt_q;
    dlen_d     = dlen_q;
    kind       = KIND_HEADER;
    payload    = 8'd0;
    last       = 1'b0;

    if (err_q == ERR_NONE) begin
      case (phase_q)
        PH_RIFF, PH_RSIZE, PH_WAVE: begin
          shift_d = shifted;
          idx_d   = idx_inc;
          if (idx_inc == 4'd4) begin
            idx_d = 4'd0;
            if (phase_q == PH_RIFF) begin
              if (shifted != FOURCC_RIFF) err_d = ERR_NOT_RIFF;
              else phase_d = PH_RSIZE;
            end else if (phase_q == PH_RSIZE) begin
              phase_d = PH_WAVE;
            end else begin
              if (shifted != FOURCC_WAVE) err_d = ERR_NOT_WAVE;
              else phase_d = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          shift_d = shifted;
          idx_d   = idx_inc;
          if (idx_inc == 4'd4) begin
            tag_d = shifted;
          end else if (idx_inc == 4'd8) begin
            // chunk header complete, size in shifted
            idx_d = 4'd0;
            if (tag_q == FOURCC_FMT) begin
              if (shifted < FMT_MIN_SIZE) begin
                err_d = ERR_FMT_SMALL;
              end else begin
                fmt_seen_d = 1'b0;
                left_d     = {1'b0, shifted - FMT_MIN_SIZE} + {32'd0, shifted[0]};
                phase_d    = PH_FMT;
              end
            end else if (tag_q == FOURCC_DATA) begin
              if (!fmt_seen_q) begin
                err_d = ERR_DATA_EARLY;
              end else begin
                dlen_d  = shifted;
                left_d  = {1'b0, shifted};
                phase_d = (shifted != 32'd0) ? PH_PAYLOAD : PH_DONE;
              end
            end else begin
              left_d  = {1'b0, shifted} + {32'd0, shifted[0]};
              phase_d = (shifted != 32'd0) ? PH_SKIP : PH_HDR;
            end
          end
        end
        PH_FMT: begin
          // store body byte at its little-endian position
          for (int i = 0; i < 16; i++) begin
            if (idx_q == 4'(i)) fmt_d[i*8 +: 8] = byte_i;
          end
          if (idx_q == 4'd15) begin
            idx_d = 4'd0;
            if (fmt_q[15:0] != FMT_PCM) begin
              err_d = ERR_NOT_PCM;
            end else begin
              fmt_seen_d = 1'b1;
              phase_d    = (left_q != 33'd0) ? PH_SKIP : PH_HDR;
            end
          end else begin
            idx_d = idx_inc;
          end
        end
        PH_SKIP: begin
          left_d = left_dec;
          if (left_dec == 33'd0) begin
            phase_d = PH_HDR;
            idx_d   = 4'd0;
          end
        end
        PH_PAYLOAD: begin
          kind    = KIND_PAYLOAD;
          payload = byte_i;
          left_d  = left_dec;
          if (left_dec == 33'd0) begin
            last    = 1'b1;
            phase_d = PH_DONE;
          end
        end
        default: begin
          kind = KIND_IGNORED;
        end
      endcase
      // stream ended before the data header completed
      if (err_d == ERR_NONE && eos_i && phase_d != PH_PAYLOAD && phase_d != PH_DONE) begin
        err_d = ERR_INCOMPLETE;
      end
    end

    if (err_d != ERR_NONE) begin
      kind    = KIND_ERROR;
      payload = 8'd0;
      last    = 1'b0;
    end
  end

  // Result word from the updated state
  always_comb begin
    res_o.kind            = kind;
    res_o.error_code      = err_d;
    res_o.payload_byte    = payload;
    res_o.last_payload    = last;
    res_o.format_valid    = fmt_seen_d;
    res_o.channels        = fmt_seen_d ? fmt_d[31:16]   : 16'd0;
    res_o.sample_rate     = fmt_seen_d ? fmt_d[63:32]   : 32'd0;
    res_o.byte_rate       = fmt_seen_d ? fmt_d[95:64]   : 32'd0;
    res_o.block_align     = fmt_seen_d ? fmt_d[111:96]  : 16'd0;
    res_o.bits_per_sample = fmt_seen_d ? fmt_d[127:112] : 16'd0;
    res_o.data_size       = dlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF;
      idx_q      <= 4'd0;
      shift_q    <= 32'd0;
      tag_q      <= 32'd0;
      left_q     <= 33'd0;
      fmt_seen_q <= 1'b0;
      err_q      <= ERR_NONE;
      fmt_q      <= 128'd0;
      dlen_q     <= 32'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      shift_q    <= shift_d;
      tag_q      <= tag_d;
      left_q     <= left_d;
      fmt_seen_q <= fmt_seen_d;
      err_q      <= err_d;
      fmt_q      <= fmt_d;
      dlen_q     <= dlen_d;
    end
  end

endmodule

// File: hdl/wrp_out_stage.sv
// ----------------------------------------------------------------------------
// wrp_out_stage
// Result register driving the output stream; holds its word while stalled.
// ----------------------------------------------------------------------------
module wrp_out_stage
  import wrp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  wrp_res_t res_i,
  output logic     advance_o,  // register can take a new word
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output wrp_res_t res_o
);

  logic     valid_q, valid_d;
  wrp_res_t res_q;

  assign advance_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WAV RIFF stream parser. One WAV file is built
// per run: a fixed opening, then random chunks (unknown, fmt, odd sizes,
// repeated fmt), then an ending that the seed picks: a data chunk with
// payload, or one of the header errors. Bytes are streamed in with random
// gaps, results are drained with random stalls, and every result word is
// compared against a software walk of the same file.
// ----------------------------------------------------------------------------
module tb_top;
  import wrp_pkg::*;

  localparam int unsigned FILE_BYTES  = 1150;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [3:0] {
    ST_RIFF, ST_RSIZE, ST_WAVE, ST_HDR, ST_FMT, ST_SKIP, ST_PAYLOAD, ST_DONE
  } walk_phase_e;

  // Software walk of the RIFF chunk structure; holds the expected words
  class wav_parse_scoreboard;
    walk_phase_e walk_phase;
    logic [3:0]  byte_pos;
    logic [31:0] shift_reg;
    logic [31:0] hdr_tag;
    logic [32:0] bytes_left;
    logic        fmt_ok;
    logic [2:0]  err_code;
    logic [63:0] fmt_word [2];
    logic [31:0] data_len;
    wrp_res_t    expected_q [$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned payload_words;
    int unsigned ignored_words;
    int unsigned error_words;

    function new();
      walk_phase    = ST_RIFF;
      byte_pos      = '0;
      shift_reg     = '0;
      hdr_tag       = '0;
      bytes_left    = '0;
      fmt_ok        = 1'b0;
      err_code      = ERR_NONE;
      fmt_word[0]   = '0;
      fmt_word[1]   = '0;
      data_len      = '0;
      mismatches    = 0;
      words_checked = 0;
      payload_words = 0;
      ignored_words = 0;
      error_words   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the walk by one accepted byte and queue the word it yields
    function void note_byte(logic [7:0] b, bit eos);
      logic [31:0] size;
      logic [1:0]  kind;
      logic [7:0]  pay;
      logic        lastp;
      wrp_res_t    res;
      kind  = KIND_HEADER;
      pay   = '0;
      lastp = 1'b0;
      if (err_code == ERR_NONE) begin
        case (walk_phase)
          ST_RIFF, ST_RSIZE, ST_WAVE: begin
            shift_reg = {b, shift_reg[31:8]};
            byte_pos  = byte_pos + 4'd1;
            if (byte_pos == 4'd4) begin
              byte_pos = '0;
              if (walk_phase == ST_RIFF) begin
                if (shift_reg != FOURCC_RIFF) err_code = ERR_NOT_RIFF;
                else walk_phase = ST_RSIZE;
              end else if (walk_phase == ST_RSIZE) begin
                walk_phase = ST_WAVE;
              end else begin
                if (shift_reg != FOURCC_WAVE) err_code = ERR_NOT_WAVE;
                else walk_phase = ST_HDR;
              end
            end
          end
          ST_HDR: begin
            shift_reg = {b, shift_reg[31:8]};
            byte_pos  = byte_pos + 4'd1;
            if (byte_pos == 4'd4) begin
              hdr_tag = shift_reg;
            end else if (byte_pos == 4'd8) begin
              // chunk header complete: tag plus little-endian size
              size     = shift_reg;
              byte_pos = '0;
              if (hdr_tag == FOURCC_FMT) begin
                if (size < FMT_MIN_SIZE) begin
                  err_code = ERR_FMT_SMALL;
                end else begin
                  fmt_ok     = 1'b0;
                  bytes_left = {1'b0, size - FMT_MIN_SIZE} + {32'd0, size[0]};
                  walk_phase = ST_FMT;
                end
              end else if (hdr_tag == FOURCC_DATA) begin
                if (!fmt_ok) begin
                  err_code = ERR_DATA_EARLY;
                end else begin
                  data_len   = size;
                  bytes_left = {1'b0, size};
                  walk_phase = (size != 0) ? ST_PAYLOAD : ST_DONE;
                end
              end else begin
                bytes_left = {1'b0, size} + {32'd0, size[0]};
                walk_phase = (bytes_left != 0) ? ST_SKIP : ST_HDR;
              end
            end
          end
          ST_FMT: begin
            fmt_word[byte_pos[3]][byte_pos[2:0]*8 +: 8] = b;
            if (byte_pos == 4'd15) begin
              byte_pos = '0;
              if (fmt_word[0][15:0] != FMT_PCM) begin
                err_code = ERR_NOT_PCM;
              end else begin
                fmt_ok     = 1'b1;
                walk_phase = (bytes_left != 0) ? ST_SKIP : ST_HDR;
              end
            end else begin
              byte_pos = byte_pos + 4'd1;
            end
          end
          ST_SKIP: begin
            bytes_left = bytes_left - 33'd1;
            if (bytes_left == 0) begin
              walk_phase = ST_HDR;
              byte_pos   = '0;
            end
          end
          ST_PAYLOAD: begin
            kind       = KIND_PAYLOAD;
            pay        = b;
            bytes_left = bytes_left - 33'd1;
            if (bytes_left == 0) begin
              lastp      = 1'b1;
              walk_phase = ST_DONE;
            end
          end
          default: kind = KIND_IGNORED;
        endcase
        // end of file before the data header is in
        if (err_code == ERR_NONE && eos && walk_phase != ST_PAYLOAD &&
            walk_phase != ST_DONE)
          err_code = ERR_INCOMPLETE;
      end
      if (err_code != ERR_NONE) begin
        kind  = KIND_ERROR;
        pay   = '0;
        lastp = 1'b0;
      end

      res                 = '0;
      res.kind            = kind;
      res.error_code      = err_code;
      res.payload_byte    = pay;
      res.last_payload    = lastp;
      res.format_valid    = fmt_ok;
      res.data_size       = data_len;
      if (fmt_ok) begin
        res.channels        = fmt_word[0][31:16];
        res.sample_rate     = fmt_word[0][63:32];
        res.byte_rate       = fmt_word[1][31:0];
        res.block_align     = fmt_word[1][47:32];
        res.bits_per_sample = fmt_word[1][63:48];
      end
      expected_q.push_back(res);
    endfunction

    function void cmp(string fld, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: %s mismatch, expected %0h, got %0h",
                   words_checked, fld, e, a);
      end
    endfunction

    // Compare one drained word with the oldest expectation
    function void check_word(logic [1:0] kind, logic [OUT_TDATA_W-1:0] data,
                             logic lastp);
      wrp_res_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: unexpected result, kind %0d", words_checked, kind);
        words_checked++;
        return;
      end
      e = expected_q.pop_front();
      cmp("kind",            32'(e.kind),            32'(kind));
      cmp("error_code",      32'(e.error_code),      32'(data[2:0]));
      cmp("payload_byte",    32'(e.payload_byte),    32'(data[10:3]));
      cmp("last_payload",    32'(e.last_payload),    32'(lastp));
      cmp("format_valid",    32'(e.format_valid),    32'(data[11]));
      cmp("channels",        32'(e.channels),        32'(data[27:12]));
      cmp("sample_rate",     e.sample_rate,          data[59:28]);
      cmp("byte_rate",       e.byte_rate,            data[91:60]);
      cmp("block_align",     32'(e.block_align),     32'(data[107:92]));
      cmp("bits_per_sample", 32'(e.bits_per_sample), 32'(data[123:108]));
      cmp("data_size",       e.data_size,            data[155:124]);
      case (e.kind)
        KIND_PAYLOAD: payload_words++;
        KIND_IGNORED: ignored_words++;
        KIND_ERROR:   error_words++;
        default: ;
      endcase
      words_checked++;
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [1:0]             m_axis_tuser;

  wav_riff_stream_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  wav_parse_scoreboard sb = new();

  logic [7:0]  file_bytes [$];
  bit          file_eos   [$];
  logic [2:0]  file_ending;
  int unsigned cycle_cnt = 0;

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- file builder ----
  function automatic void put_byte(logic [7:0] b, bit eos = 1'b0);
    file_bytes.push_back(b);
    file_eos.push_back(eos);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) put_byte(v[k*8 +: 8]);
  endfunction

  // Unknown chunk with a random tag; the body may be cut short
  function automatic void put_unknown(logic [31:0] size, int body_len);
    logic [31:0] tag;
    tag = $urandom();
    if (tag == FOURCC_FMT || tag == FOURCC_DATA) tag = ~tag;
    put_le(tag, 4);
    put_le(size, 4);
    for (int k = 0; k < body_len; k++) put_byte(8'($urandom_range(0, 255)));
    if (body_len == size && size[0]) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_fmt(logic [31:0] size, logic [15:0] fmt_tag,
                                  bit extremes);
    put_le(FOURCC_FMT, 4);
    put_le(size, 4);
    if (size < FMT_MIN_SIZE) return;
    put_le(32'(fmt_tag), 2);
    if (extremes) begin
      put_le(32'h0000_FFFF, 2);   // channels
      put_le(32'h0000_0000, 4);   // sample rate
      put_le(32'hFFFF_FFFF, 4);   // byte rate
      put_le(32'h0000_0000, 2);   // block align
      put_le(32'h0000_FFFF, 2);   // bits per sample
    end else begin
      put_le($urandom(), 2);
      put_le($urandom(), 4);
      put_le($urandom(), 4);
      put_le($urandom(), 2);
      put_le($urandom(), 2);
    end
    for (int k = 16; k < size; k++) put_byte(8'($urandom_range(0, 255)));
    if (size[0]) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_file();
    int          pick;
    int          mid_target;
    int          n_pay;
    logic [31:0] size;
    logic [15:0] bad_tag;
    pick = $urandom_range(0, 19);
    if (pick == 0)      file_ending = ERR_NOT_RIFF;
    else if (pick == 1) file_ending = ERR_NOT_WAVE;
    else if (pick < 4)  file_ending = ERR_FMT_SMALL;
    else if (pick < 6)  file_ending = ERR_NOT_PCM;
    else if (pick < 8)  file_ending = ERR_DATA_EARLY;
    else if (pick < 10) file_ending = ERR_INCOMPLETE;
    else                file_ending = ERR_NONE;

    // fixed opening: tags, extreme or random RIFF size, odd and empty chunks
    put_le(FOURCC_RIFF, 4);
    put_le($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom(), 4);
    put_le(FOURCC_WAVE, 4);
    put_unknown(32'd1, 1);
    put_unknown(32'd0, 0);
    if (file_ending != ERR_DATA_EARLY) put_fmt(32'd17, FMT_PCM, 1'b1);

    // random chunk walk
    mid_target = (file_ending == ERR_NONE || file_ending == ERR_NOT_RIFF ||
                  file_ending == ERR_NOT_WAVE) ? 550 : 850;
    while (file_bytes.size() < mid_target) begin
      if ($urandom_range(0, 9) < 6 || file_ending == ERR_DATA_EARLY) begin
        size = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 24)
                                            : $urandom_range(25, 160);
        put_unknown(size, size);
      end else begin
        put_fmt($urandom_range(16, 40), FMT_PCM, 1'b0);
      end
    end

    // ending picked above
    case (file_ending)
      ERR_FMT_SMALL: put_fmt($urandom_range(0, 15), FMT_PCM, 1'b0);
      ERR_NOT_PCM: begin
        case ($urandom_range(0, 3))
          0:       bad_tag = 16'h0000;
          1:       bad_tag = 16'hFFFF;
          2:       bad_tag = 16'h0003;
          default: bad_tag = 16'($urandom());
        endcase
        if (bad_tag == FMT_PCM) bad_tag = 16'h0000;
        put_fmt($urandom_range(16, 24), bad_tag, 1'b0);
      end
      ERR_DATA_EARLY: begin
        put_le(FOURCC_DATA, 4);
        put_le($urandom_range(0, 64), 4);
      end
      ERR_INCOMPLETE: begin
        if ($urandom_range(0, 1)) begin
          // inside a skip too long to finish
          put_unknown(32'hFFFF_FFFF, $urandom_range(1, 100));
          file_eos[file_eos.size()-1] = 1'b1;
        end else begin
          file_eos[$urandom_range(0, file_eos.size()-1)] = 1'b1;
        end
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       size = 32'd0;
          1:       size = 32'd1;
          2:       size = 32'hFFFF_FFFF;
          default: size = $urandom_range(2, 500);
        endcase
        put_le(FOURCC_DATA, 4);
        put_le(size, 4);
        if ($urandom_range(0, 3) == 0) file_eos[file_eos.size()-1] = 1'b1;
        n_pay = (size == 32'hFFFF_FFFF) ? 400 : size;
        for (int k = 0; k < n_pay; k++)
          put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 31) == 0);
      end
    endcase

    // trailing bytes, processed as if the stream went on
    while (file_bytes.size() < FILE_BYTES)
      put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    file_eos[file_eos.size()-1] = 1'b1;

    if (file_ending == ERR_NOT_RIFF)
      file_bytes[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
    else if (file_ending == ERR_NOT_WAVE)
      file_bytes[$urandom_range(8, 11)] ^= 8'h01 << $urandom_range(0, 7);
  endfunction

  // ---- drivers ----
  task automatic send_byte(input logic [7:0] b, input bit eos, input int gap,
                           input bit hold);
    @(negedge clk_i);
    if (gap != 0 || hold) begin
      s_axis_tvalid <= 1'b0;
      if (hold) begin
        do @(negedge clk_i); while (sb.pending() != 0);
      end
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, eos);
  endtask

  // Result drain with random stalls
  initial begin
    int stall;
    bit calm;
    int n;
    n    = 0;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (n % 48 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      n++;
    end
  end

  // Main sequence
  initial begin
    string ending_name;
    bit    calm;
    bit    hold;
    int    gap;
    calm = 1'b0;
    build_file();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      hold = (i == file_bytes.size() / 2) || ($urandom_range(0, 199) == 0);
      gap  = calm ? 0 : $urandom_range(0, 7);
      send_byte(file_bytes[i], file_eos[i], gap, hold);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    case (file_ending)
      ERR_NOT_RIFF:   ending_name = "bad RIFF tag";
      ERR_NOT_WAVE:   ending_name = "bad WAVE tag";
      ERR_FMT_SMALL:  ending_name = "short fmt chunk";
      ERR_NOT_PCM:    ending_name = "non-PCM fmt";
      ERR_DATA_EARLY: ending_name = "data before fmt";
      ERR_INCOMPLETE: ending_name = "early end of stream";
      default:        ending_name = "data chunk payload";
    endcase
    $display("Streamed a %0d-byte WAV file ending in %s.", file_bytes.size(),
             ending_name);
    $display("Words checked %0d: payload %0d, ignored %0d, error %0d; %0d mismatches.",
             sb.words_checked, sb.payload_words, sb.ignored_words,
             sb.error_words, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/wrp_pkg.sv
hdl/wrp_in_stage.sv
hdl/wrp_core.sv
hdl/wrp_out_stage.sv
hdl/wav_riff_stream_parser.sv
sim/tb_top.sv
